// File: rtl/assert_macros.svh
// Assertion helpers used by the sequencer of the truss stiffness scatter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/tsds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Truss stiffness scatter package
// Shared types, constants and index tables of the truss stiffness scatter unit.
// ----------------------------------------------------------------------------
package tsds_pkg;

    localparam int NODE_BITS_DEF   = 20;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int DOF_PER_NODE    = 3;
    localparam int NODE_W          = 20;
    localparam int IDX_W           = 22;
    localparam int COORD_W         = 32;
    localparam int STIFF_W         = 48;
    localparam int COS_W           = 31;
    localparam int DIV_STEPS       = 31;
    localparam int PROD_COUNT      = 6;
    localparam int SLOT_COUNT      = 9;
    localparam int ACC_W           = 111;

    typedef struct packed {
        logic        [NODE_W-1:0]  node_a;
        logic        [NODE_W-1:0]  node_b;
        logic signed [COORD_W-1:0] xa;
        logic signed [COORD_W-1:0] ya;
        logic signed [COORD_W-1:0] za;
        logic signed [COORD_W-1:0] xb;
        logic signed [COORD_W-1:0] yb;
        logic signed [COORD_W-1:0] zb;
        logic        [COORD_W-1:0] elem_length;
        logic signed [STIFF_W-1:0] stiff_old;
        logic signed [STIFF_W-1:0] stiff_new;
    } in_item_t;

    typedef struct packed {
        logic        [IDX_W-1:0]   row_index;
        logic        [IDX_W-1:0]   col_index;
        logic signed [STIFF_W-1:0] increment;
        logic                      last;
    } out_item_t;

    // One element after the arithmetic: base indices and the six rounded
    // increment magnitudes (capped at 2^47) with their signs for node pair (a,a).
    typedef struct packed {
        logic [IDX_W-1:0]                    base_a;
        logic [IDX_W-1:0]                    base_b;
        logic [PROD_COUNT-1:0][STIFF_W-1:0]  mag;
        logic [PROD_COUNT-1:0]               neg;
    } elem_rec_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIV,
        FRONT_MUL,
        FRONT_PUSH
    } front_state_t;

    function automatic logic [1:0] prod_axis_i(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd1, 3'd3, 3'd4: r = 2'd1;
            3'd2, 3'd5:       r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] prod_axis_j(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd3:       r = 2'd1;
            3'd4, 3'd5: r = 2'd2;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] slot_prod(input logic [3:0] s);
        logic [2:0] r;
        case (s)
            4'd1, 4'd2: r = 3'd1;
            4'd3, 4'd4: r = 3'd2;
            4'd5:       r = 3'd3;
            4'd6, 4'd7: r = 3'd4;
            4'd8:       r = 3'd5;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] slot_roff(input logic [3:0] s);
        logic [1:0] r;
        case (s)
            4'd1, 4'd5, 4'd6: r = 2'd1;
            4'd3, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] slot_coff(input logic [3:0] s);
        logic [1:0] r;
        case (s)
            4'd2, 4'd5, 4'd7: r = 2'd1;
            4'd4, 4'd6, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tsds_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Truss stiffness scatter front end
// Buffers one element, divides the coordinate differences by the length and
// forms the six rounded increment magnitudes with a shared multiplier.
// ----------------------------------------------------------------------------
module tsds_front
    import tsds_pkg::*;
#(
    parameter int NODE_BITS = NODE_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  in_item,
    output logic           rec_push,
    input  wire logic      rec_full,
    output elem_rec_t      rec
);

    localparam int KEEP_BITS = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;
    localparam logic [NODE_W-1:0] NODE_MASK =
        NODE_W'((( (NODE_W+1)'(1)) << KEEP_BITS) - (NODE_W+1)'(1));
    localparam logic [COS_W-1:0] COS_MAX = {COS_W{1'b1}};
    localparam logic [STIFF_W-1:0] MAG_CAP = {1'b1, {(STIFF_W-1){1'b0}}};

    front_state_t state_reg, state_next;

    logic       buf_valid_reg, buf_valid_next;
    in_item_t   buf_reg;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] prod_reg, prod_next;
    logic [2:0] step_reg, step_next;

    logic [COORD_W-1:0]   len_reg;
    logic [COORD_W-1:0]   rem_reg [3];
    logic [COS_W-1:0]     q_reg [3];
    logic [2:0]           sat_reg;
    logic [2:0]           csign_reg;
    logic [2:0]           low_reg;
    logic [STIFF_W:0]     amag_reg;
    logic                 dsign_reg;
    logic [IDX_W-1:0]     base_a_reg, base_b_reg;
    logic [2*COS_W-1:0]   pq_reg;
    logic                 psign_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [PROD_COUNT-1:0][STIFF_W-1:0] mag_reg;
    logic [PROD_COUNT-1:0] neg_reg;

    logic                 accept;
    logic                 take;
    logic                 len_zero;
    logic                 div_last;
    logic                 prod_done;
    logic                 all_zero;
    logic [COORD_W:0]     diff   [3];
    logic [COORD_W:0]     dmag   [3];
    logic [COORD_W:0]     tval   [3];
    logic [COS_W-1:0]     qeff   [3];
    logic [STIFF_W:0]     dval;
    logic [50:0]          rnd;
    logic [STIFF_W-1:0]   rcap;
    logic [55:0]          pp;
    logic [ACC_W-1:0]     pp_sh;
    logic [1:0]           ai, aj;

    assign accept   = push && !full;
    assign full     = buf_valid_reg;
    assign len_zero = (buf_reg.elem_length == '0);
    assign div_last = (cnt_reg == 5'(DIV_STEPS - 1));
    assign prod_done = (step_reg == 3'd5);
    assign ai = prod_axis_i(prod_reg);
    assign aj = prod_axis_j(prod_reg);

    always_comb
    begin
        diff[0] = {buf_reg.xb[COORD_W-1], buf_reg.xb} - {buf_reg.xa[COORD_W-1], buf_reg.xa};
        diff[1] = {buf_reg.yb[COORD_W-1], buf_reg.yb} - {buf_reg.ya[COORD_W-1], buf_reg.ya};
        diff[2] = {buf_reg.zb[COORD_W-1], buf_reg.zb} - {buf_reg.za[COORD_W-1], buf_reg.za};
        for (int k = 0; k < 3; k++)
        begin
            dmag[k] = diff[k][COORD_W] ? -diff[k] : diff[k];
            tval[k] = {rem_reg[k], ((cnt_reg == 5'd0) ? low_reg[k] : 1'b0)};
            qeff[k] = sat_reg[k] ? COS_MAX : q_reg[k];
        end
        dval = {buf_reg.stiff_new[STIFF_W-1], buf_reg.stiff_new}
             - {buf_reg.stiff_old[STIFF_W-1], buf_reg.stiff_old};
    end

    always_comb
    begin
        case (step_reg)
            3'd1:    pp = 56'(amag_reg[24:0] * pq_reg[30:0]);
            3'd2:    pp = 56'(amag_reg[24:0] * pq_reg[61:31]);
            3'd3:    pp = 56'(amag_reg[48:25] * pq_reg[30:0]);
            default: pp = 56'(amag_reg[48:25] * pq_reg[61:31]);
        endcase
        case (step_reg)
            3'd1:    pp_sh = ACC_W'(pp);
            3'd2:    pp_sh = ACC_W'(pp) << 31;
            3'd3:    pp_sh = ACC_W'(pp) << 25;
            default: pp_sh = ACC_W'(pp) << 56;
        endcase
        rnd  = acc_reg[ACC_W-1:60];
        rcap = (rnd > 51'(MAG_CAP)) ? MAG_CAP : rnd[STIFF_W-1:0];
        all_zero = (rcap == '0);
        for (int p = 0; p < PROD_COUNT - 1; p++)
        begin
            all_zero = all_zero && (mag_reg[p] == '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (buf_valid_reg && !len_zero)
                begin
                    state_next = FRONT_DIV;
                end
            end
            FRONT_DIV:
            begin
                if (div_last)
                begin
                    state_next = FRONT_MUL;
                end
            end
            FRONT_MUL:
            begin
                if (prod_done && prod_reg == 3'(PROD_COUNT - 1))
                begin
                    state_next = all_zero ? FRONT_IDLE : FRONT_PUSH;
                end
            end
            FRONT_PUSH:
            begin
                if (!rec_full)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default: state_next = FRONT_IDLE;
        endcase
    end

    always_comb
    begin
        take     = 1'b0;
        rec_push = 1'b0;
        unique case (state_reg)
            FRONT_IDLE: take     = buf_valid_reg;
            FRONT_PUSH: rec_push = !rec_full;
            default:    ;
        endcase
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (accept)
        begin
            buf_valid_next = 1'b1;
        end
        else if (take)
        begin
            buf_valid_next = 1'b0;
        end
        cnt_next  = (state_reg == FRONT_DIV) ? cnt_reg + 5'd1 : 5'd0;
        prod_next = prod_reg;
        step_next = step_reg;
        if (state_reg == FRONT_MUL)
        begin
            step_next = prod_done ? 3'd0 : step_reg + 3'd1;
            if (prod_done)
            begin
                prod_next = (prod_reg == 3'(PROD_COUNT - 1)) ? 3'd0 : prod_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FRONT_IDLE;
            buf_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            prod_reg      <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            cnt_reg       <= cnt_next;
            prod_reg      <= prod_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= in_item;
        end
        if (take)
        begin
            len_reg    <= buf_reg.elem_length;
            amag_reg   <= dval[STIFF_W] ? -dval : dval;
            dsign_reg  <= dval[STIFF_W];
            base_a_reg <= IDX_W'(buf_reg.node_a & NODE_MASK) * IDX_W'(DOF_PER_NODE);
            base_b_reg <= IDX_W'(buf_reg.node_b & NODE_MASK) * IDX_W'(DOF_PER_NODE);
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k]   <= dmag[k][COORD_W:1];
                low_reg[k]   <= dmag[k][0];
                sat_reg[k]   <= (dmag[k] >= {buf_reg.elem_length, 1'b0});
                csign_reg[k] <= diff[k][COORD_W];
                q_reg[k]     <= '0;
            end
        end
        if (state_reg == FRONT_DIV)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (tval[k] >= {1'b0, len_reg})
                begin
                    rem_reg[k] <= COORD_W'(tval[k] - {1'b0, len_reg});
                    q_reg[k]   <= {q_reg[k][COS_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= tval[k][COORD_W-1:0];
                    q_reg[k]   <= {q_reg[k][COS_W-2:0], 1'b0};
                end
            end
        end
        if (state_reg == FRONT_MUL)
        begin
            if (step_reg == 3'd0)
            begin
                pq_reg    <= qeff[ai] * qeff[aj];
                psign_reg <= csign_reg[ai] ^ csign_reg[aj];
                acc_reg   <= ACC_W'(1) << 59;
            end
            else if (!prod_done)
            begin
                acc_reg <= acc_reg + pp_sh;
            end
            else
            begin
                mag_reg[prod_reg] <= rcap;
                neg_reg[prod_reg] <= psign_reg ^ dsign_reg;
            end
        end
    end

    assign rec.base_a = base_a_reg;
    assign rec.base_b = base_b_reg;
    assign rec.mag    = mag_reg;
    assign rec.neg    = neg_reg;

endmodule
`default_nettype wire

// File: rtl/tsds_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Truss stiffness scatter element queue
// A short first-in first-out queue of element records between the front end
// and the update sequencer.
// ----------------------------------------------------------------------------
module tsds_queue
    import tsds_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    output logic           full,
    input  wire elem_rec_t wr_data,
    output logic           rd_valid,
    input  wire logic      rd_en,
    output elem_rec_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    elem_rec_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tsds_back.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Truss stiffness scatter update sequencer
// Walks the four node pairs of a queued element and issues one nonzero matrix
// update per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module tsds_back
    import tsds_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      rec_valid,
    input  wire elem_rec_t rec,
    output logic           rec_pop,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      out_item
);

    localparam logic [STIFF_W-1:0] MAG_CAP = {1'b1, {(STIFF_W-1){1'b0}}};

    logic [3:0]   slot_reg, slot_next;
    logic [1:0]   pair_reg, pair_next;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_reg;

    logic [SLOT_COUNT-1:0] slot_nz;
    logic         found;
    logic [3:0]   sel;
    logic         later_nz;
    logic         emit;
    logic         emit_last;
    logic [2:0]   pidx;
    logic [STIFF_W-1:0] m;
    logic         ng;
    out_item_t    upd;

    always_comb
    begin
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            slot_nz[s] = (rec.mag[slot_prod(4'(s))] != '0);
        end
        found = 1'b0;
        sel   = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (4'(s) >= slot_reg && slot_nz[s])
            begin
                found = 1'b1;
                sel   = 4'(s);
            end
        end
        later_nz = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            if (4'(s) > sel && slot_nz[s])
            begin
                later_nz = 1'b1;
            end
        end
    end

    assign emit      = rec_valid && found && (!out_valid_reg || pop);
    assign emit_last = (pair_reg == 2'd3) && !later_nz;
    assign rec_pop   = emit && emit_last;

    always_comb
    begin
        pidx = slot_prod(sel);
        m    = rec.mag[pidx];
        ng   = rec.neg[pidx] ^ pair_reg[1] ^ pair_reg[0];
        upd.row_index = (pair_reg[1] ? rec.base_b : rec.base_a) + IDX_W'(slot_roff(sel));
        upd.col_index = (pair_reg[0] ? rec.base_b : rec.base_a) + IDX_W'(slot_coff(sel));
        if (ng)
        begin
            upd.increment = -m;
        end
        else
        begin
            upd.increment = (m == MAG_CAP) ? MAG_CAP - STIFF_W'(1) : m;
        end
        upd.last = emit_last;
    end

    always_comb
    begin
        slot_next      = slot_reg;
        pair_next      = pair_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (later_nz)
            begin
                slot_next = sel + 4'd1;
            end
            else
            begin
                slot_next = '0;
                pair_next = pair_reg + 2'd1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            pair_reg      <= pair_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= upd;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    `ASSERT_NEVER(a_no_zero_update, clk, rst_n, out_valid_reg && out_reg.increment == '0,
        "A zero increment was presented as an update.")
    `ASSERT_NEVER(a_slot_range, clk, rst_n, slot_reg > 4'(SLOT_COUNT - 1),
        "The slot counter left its range.")
    `ASSERT_CLK(a_pop_at_end, clk, rst_n, rec_pop |=> (pair_reg == 2'd0 && slot_reg == 4'd0),
        "The sequencer did not restart after an element ended.")

endmodule
`default_nettype wire

// File: rtl/truss_stiffness_delta_scatter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Truss stiffness delta scatter unit
// Turns a 3D truss element's stiffness change into global matrix updates.
// ----------------------------------------------------------------------------
// The input side is a queue: an element is a transaction when push is high and
// full is low. The result side is a queue too: the oldest update sits on
// out_item while empty is low and is taken when pop is high.
// Each element yields up to 36 (row, column, increment) updates, the last one
// flagged; a zero length or all-zero increments yield none.
// The front end holds one element in an input buffer and works on it in order:
// it loads its operands, runs a bit-serial division for the three cosines in
// parallel, forms six products on the shared multiplier, then queues it.
// The sequencer issues one update per cycle while its output register is free
// or being popped. The input buffer takes the next element as soon as the
// front end has loaded the current element's operands.
// A stalled receiver holds the output register; the two-entry element queue and
// the input buffer then fill and full rises.
// Reset empties the buffer, the queue and the output register.
// ----------------------------------------------------------------------------
module truss_stiffness_delta_scatter_unit
    import tsds_pkg::*;
#(
    parameter int NODE_BITS   = NODE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     out_item
);

    logic      q_wr_en;
    logic      q_full;
    elem_rec_t q_wr_data;
    logic      q_rd_valid;
    logic      q_rd_en;
    elem_rec_t q_rd_data;

    tsds_front #(
        .NODE_BITS (NODE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .rec_push (q_wr_en),
        .rec_full (q_full),
        .rec      (q_wr_data)
    );

    tsds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr_en),
        .full     (q_full),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_en    (q_rd_en),
        .rd_data  (q_rd_data)
    );

    tsds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_rd_valid),
        .rec       (q_rd_data),
        .rec_pop   (q_rd_en),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire
